[src/rrj_pkg.sv]
// Shared types and constants for the reaction-rate and Jacobian edge evaluator.
package rrj_pkg;

  localparam int WORD_W = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    OP_TRANSCRIPTION = 3'd0,
    OP_COACTIVATION  = 3'd1,
    OP_DEGRADATION   = 3'd2,
    OP_SEQUESTRATION = 3'd3,
    OP_HILL          = 3'd4,
    OP_AGGREGATE     = 3'd5,
    OP_DISAGGREGATE  = 3'd6,
    OP_WELL          = 3'd7
  } op_e;

  // Output selection class worked out by the front end.
  typedef enum logic [2:0] {
    SEL_LIN  = 3'd0,
    SEL_PAIR = 3'd1,
    SEL_MASS = 3'd2,
    SEL_WELL = 3'd3,
    SEL_HILL = 3'd4,
    SEL_ZERO = 3'd5
  } sel_e;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [WORD_W-1:0] rate_k;
    logic signed [WORD_W-1:0] half_k;
    logic signed [WORD_W-1:0] source_level;
    logic signed [WORD_W-1:0] aux_level;
    logic signed [WORD_W-1:0] target_level;
    logic                     self_is_target;
    logic                     self_is_source;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] rate;
    logic signed [WORD_W-1:0] d_source;
    logic signed [WORD_W-1:0] d_aux;
    logic signed [WORD_W-1:0] d_target;
    logic                     hill_error;
  } result_t;

  typedef struct packed {
    sel_e                     sel;
    logic                     neg;
    logic                     err;
    logic signed [WORD_W-1:0] k;
    logic signed [WORD_W-1:0] kh;
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] z;
    logic signed [WORD_W-1:0] y;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/rrj_front.sv]
// Front end: accepts input beats and classifies each edge kind.
module rrj_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  rrj_pkg::item_t item,
  input  logic           q_full,
  output logic           q_push,
  output rrj_pkg::cls_t  q_data
);

  logic          held;
  rrj_pkg::cls_t cls;
  rrj_pkg::cls_t cls_next;

  assign q_push     = held && !q_full;
  assign item_stall = held && q_full;
  assign q_data     = cls;

  always_comb begin
    cls_next     = '0;
    cls_next.k   = item.rate_k;
    cls_next.kh  = item.half_k;
    cls_next.x   = item.source_level;
    cls_next.z   = item.aux_level;
    cls_next.y   = item.target_level;
    cls_next.sel = rrj_pkg::SEL_LIN;
    unique case (rrj_pkg::op_e'(item.opcode))
      rrj_pkg::OP_TRANSCRIPTION: begin
        cls_next.sel = rrj_pkg::SEL_LIN;
      end
      rrj_pkg::OP_COACTIVATION: begin
        cls_next.sel = rrj_pkg::SEL_PAIR;
      end
      rrj_pkg::OP_DEGRADATION, rrj_pkg::OP_SEQUESTRATION: begin
        cls_next.sel = rrj_pkg::SEL_MASS;
        cls_next.neg = 1'b1;
      end
      rrj_pkg::OP_HILL: begin
        // A half constant at or below zero flags an error and zeroes everything.
        if (item.half_k[rrj_pkg::WORD_W-1] || item.half_k == '0) begin
          cls_next.sel = rrj_pkg::SEL_ZERO;
          cls_next.err = 1'b1;
        end else begin
          cls_next.sel = rrj_pkg::SEL_HILL;
        end
      end
      rrj_pkg::OP_AGGREGATE: begin
        cls_next.sel = rrj_pkg::SEL_PAIR;
        cls_next.neg = !item.self_is_target;
      end
      rrj_pkg::OP_DISAGGREGATE: begin
        cls_next.sel = rrj_pkg::SEL_LIN;
        cls_next.neg = item.self_is_source;
      end
      rrj_pkg::OP_WELL: begin
        cls_next.sel = rrj_pkg::SEL_WELL;
        cls_next.neg = 1'b1;
      end
      default: begin
        cls_next.sel = rrj_pkg::SEL_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!item_stall) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      cls <= cls_next;
    end
  end

endmodule

[src/rrj_fifo.sv]
// Short queue of classified edges between the front and back ends.
module rrj_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rrj_pkg::cls_t     push_data,
  input  logic              pop,
  output rrj_pkg::cls_t     head,
  output rrj_pkg::q_stat_t  stat
);

  rrj_pkg::cls_t                 mem [rrj_pkg::QDEPTH];
  logic [rrj_pkg::QPTR_W-1:0]    wr_ptr;
  logic [rrj_pkg::QPTR_W-1:0]    rd_ptr;
  logic [rrj_pkg::QPTR_W:0]      count;

  assign stat.full  = (count == (rrj_pkg::QPTR_W + 1)'(rrj_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[src/rrj_back.sv]
// Back end: multiplier stages, pipelined Hill dividers and the output register.
module rrj_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  rrj_pkg::cls_t    q_head,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output rrj_pkg::result_t result
);

  localparam int W  = rrj_pkg::WORD_W;
  localparam int P  = 2 * W;
  localparam int NB = W + FRAC_BITS;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [P-1:0]  NLIM = P'(1) << (W - 1);
  localparam logic [P-1:0]  PLIM = NLIM - P'(1);
  localparam logic [NB-1:0] QNLIM = NB'(1) << (W - 1);
  localparam logic [NB-1:0] QPLIM = QNLIM - NB'(1);

  typedef struct packed {
    logic [W-1:0]  rem;
    logic [NB-1:0] quo;
    logic [NB-1:0] num;
  } dv_t;

  typedef struct packed {
    logic signed [W-1:0] rate;
    logic signed [W-1:0] ds;
    logic signed [W-1:0] da;
    logic signed [W-1:0] dt;
    logic signed [W-1:0] k;
    logic                hill;
    logic                err;
    logic                xneg;
  } hp_t;

  function automatic logic signed [W-1:0] smul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [P-1:0] p;
    logic [P-1:0]        m;
    logic [P-1:0]        r;
    p = P'(a) * P'(b);
    m = p[P-1] ? $unsigned(-p) : $unsigned(p);
    r = m >> FRAC_BITS;
    if (p[P-1]) begin
      smul = (r > NLIM) ? VMIN : $signed(~r[W-1:0] + 1'b1);
    end else begin
      smul = (r > PLIM) ? VMAX : $signed(r[W-1:0]);
    end
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = (W + 1)'(a) + (W + 1)'(b);
    if (s[W] != s[W-1]) begin
      sadd = s[W] ? VMIN : VMAX;
    end else begin
      sadd = s[W-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] sneg(input logic signed [W-1:0] v);
    sneg = (v == VMIN) ? VMAX : -v;
  endfunction

  function automatic logic signed [W-1:0] qsat(input logic neg, input logic [NB-1:0] q);
    if (neg) begin
      qsat = (q > QNLIM) ? VMIN : $signed(~q[W-1:0] + 1'b1);
    end else begin
      qsat = (q > QPLIM) ? VMAX : $signed(q[W-1:0]);
    end
  endfunction

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  function automatic dv_t dstep(input dv_t s, input logic [W-1:0] d);
    dv_t          o;
    logic [W-1:0] r;
    r     = {s.rem[W-2:0], s.num[NB-1]};
    o.num = s.num << 1;
    if (r >= d) begin
      o.rem = r - d;
      o.quo = {s.quo[NB-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {s.quo[NB-2:0], 1'b0};
    end
    return o;
  endfunction

  logic en;

  // Stage 1 to 3: products.
  logic                v1, v2, v3;
  rrj_pkg::cls_t       c1, c2, c3;
  logic signed [W-1:0] a1, b1, h1, x21;
  logic signed [W-1:0] a2, b2, h2, x22, cc2, e2, f2, den2;
  logic signed [W-1:0] a3, b3, h3, x23, cc3, e3, f3, den3, g3;

  // Divider pipeline.
  dv_t          dv_in [3];
  dv_t          dv    [NB][3];
  logic [W-1:0] dd    [NB];
  hp_t          hp    [NB];
  logic         dvv   [NB];
  hp_t          hp_in;
  logic [W-1:0] xmag;

  // Post-division stages.
  logic                pv1, pv2;
  hp_t                 ph1, ph2;
  logic signed [W-1:0] r1, u1, q31, r2, t2;

  assign en  = !(result_valid && result_stall);
  assign pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1   <= q_head;
      a1   <= smul(q_head.k, q_head.x);
      b1   <= smul(q_head.k, q_head.y);
      h1   <= smul(q_head.k, q_head.z);
      x21  <= smul(q_head.x, q_head.x);
      c2   <= c1;
      a2   <= a1;
      b2   <= b1;
      h2   <= h1;
      x22  <= x21;
      cc2  <= smul(a1, c1.z);
      e2   <= smul(b1, c1.z);
      f2   <= smul(b1, c1.x);
      den2 <= sadd(c1.kh, x21);
      c3   <= c2;
      a3   <= a2;
      b3   <= b2;
      h3   <= h2;
      x23  <= x22;
      cc3  <= cc2;
      e3   <= e2;
      f3   <= f2;
      den3 <= den2;
      g3   <= smul(cc2, c2.y);
    end
  end

  // Mass-action results are settled here and ride alongside the dividers.
  always_comb begin
    hp_in      = '0;
    hp_in.k    = c3.k;
    hp_in.err  = c3.err;
    hp_in.hill = (c3.sel == rrj_pkg::SEL_HILL);
    hp_in.xneg = c3.x[W-1];
    unique case (c3.sel)
      rrj_pkg::SEL_LIN: begin
        hp_in.rate = a3;
        hp_in.ds   = c3.k;
      end
      rrj_pkg::SEL_PAIR: begin
        hp_in.rate = cc3;
        hp_in.ds   = h3;
        hp_in.da   = a3;
      end
      rrj_pkg::SEL_MASS: begin
        hp_in.rate = f3;
        hp_in.ds   = b3;
        hp_in.dt   = a3;
      end
      rrj_pkg::SEL_WELL: begin
        hp_in.rate = g3;
        hp_in.ds   = e3;
        hp_in.da   = f3;
        hp_in.dt   = cc3;
      end
      rrj_pkg::SEL_HILL, rrj_pkg::SEL_ZERO: begin
        hp_in.rate = '0;
      end
      default: begin
        hp_in.rate = '0;
      end
    endcase
    if (c3.neg) begin
      hp_in.rate = sneg(hp_in.rate);
      hp_in.ds   = sneg(hp_in.ds);
      hp_in.da   = sneg(hp_in.da);
      hp_in.dt   = sneg(hp_in.dt);
    end
  end

  // Three quotients: x^2/den, kh/den and x/den, each scaled by 2^FRAC_BITS.
  always_comb begin
    xmag         = c3.x[W-1] ? $unsigned(-c3.x) : $unsigned(c3.x);
    dv_in[0].rem = '0;
    dv_in[0].quo = '0;
    dv_in[0].num = NB'($unsigned(x23)) << FRAC_BITS;
    dv_in[1].rem = '0;
    dv_in[1].quo = '0;
    dv_in[1].num = NB'($unsigned(c3.kh)) << FRAC_BITS;
    dv_in[2].rem = '0;
    dv_in[2].quo = '0;
    dv_in[2].num = NB'(xmag) << FRAC_BITS;
  end

  for (genvar j = 0; j < NB; j++) begin : g_div
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          dvv[0] <= 1'b0;
        end else if (en) begin
          dvv[0] <= v3;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          for (int l = 0; l < 3; l++) begin
            dv[0][l] <= dstep(dv_in[l], $unsigned(den3));
          end
          dd[0] <= $unsigned(den3);
          hp[0] <= hp_in;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          dvv[j] <= 1'b0;
        end else if (en) begin
          dvv[j] <= dvv[j-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          for (int l = 0; l < 3; l++) begin
            dv[j][l] <= dstep(dv[j-1][l], dd[j-1]);
          end
          dd[j] <= dd[j-1];
          hp[j] <= hp[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv1          <= 1'b0;
      pv2          <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      pv1          <= dvv[NB-1];
      pv2          <= pv1;
      result_valid <= pv2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph1 <= hp[NB-1];
      r1  <= smul(hp[NB-1].k, qsat(1'b0, dv[NB-1][0].quo));
      u1  <= smul(hp[NB-1].k, qsat(1'b0, dv[NB-1][1].quo));
      q31 <= qsat(hp[NB-1].xneg, dv[NB-1][2].quo);
      ph2 <= ph1;
      r2  <= r1;
      t2  <= smul(u1, q31);
      result.hill_error <= ph2.err;
      if (ph2.hill) begin
        result.rate     <= r2;
        result.d_source <= sadd(t2, t2);
        result.d_aux    <= '0;
        result.d_target <= '0;
      end else begin
        result.rate     <= ph2.rate;
        result.d_source <= ph2.ds;
        result.d_aux    <= ph2.da;
        result.d_target <= ph2.dt;
      end
    end
  end

endmodule

[src/reaction_rate_and_jacobian.sv]
// Throughput: one edge per cycle; the whole back end advances whenever the output is free.
// The latency is set by the restoring dividers, one quotient bit per stage, used by Hill edges.
// A four-beat queue between the classifier and the arithmetic lets each side stall alone.
// Reset clears every valid bit and empties the queue; payload registers are not cleared.
module reaction_rate_and_jacobian #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  rrj_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output rrj_pkg::result_t result
);

  logic              q_push;
  logic              q_pop;
  rrj_pkg::cls_t     q_in;
  rrj_pkg::cls_t     q_head;
  rrj_pkg::q_stat_t  q_stat;

  rrj_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_stat.full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  rrj_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  rrj_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (!q_stat.empty),
    .q_head       (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.hill_error) |->
      (result.rate == '0 && result.d_source == '0 &&
       result.d_aux == '0 && result.d_target == '0))
    else $error("Hill error beat carries non-zero outputs");

endmodule

[bench/rrj_checker.sv]
// Checker for the edge evaluator: predicts each result from the accepted beats and compares.
module rrj_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  rrj_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  rrj_pkg::result_t result,
  output int               fail_count,
  output int               pending
);
  import rrj_pkg::*;

  localparam int FB = 16;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  result_t expected_q[$];

  function automatic longint clamp(input bit neg, input logic [127:0] mag);
    if (neg) begin
      if (mag > 128'd2147483648) return VMIN;
      return -longint'(mag);
    end
    if (mag > 128'd2147483647) return VMAX;
    return longint'(mag);
  endfunction

  function automatic logic [127:0] mag_of(input longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint q_neg(input longint v);
    return (v == VMIN) ? VMAX : -v;
  endfunction

  function automatic longint q_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > VMAX) return VMAX;
    if (s < VMIN) return VMIN;
    return s;
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    logic [127:0] p;
    p = (mag_of(a) * mag_of(b)) >> FB;
    return clamp((a < 0) != (b < 0), p);
  endfunction

  // Divisor is always positive here.
  function automatic longint q_div(input longint n, input longint d);
    logic [127:0] q;
    q = (mag_of(n) << FB) / 128'(d);
    return clamp(n < 0, q);
  endfunction

  function automatic result_t edge_result(input item_t it);
    result_t r;
    longint k, kh, x, z, y, rt, ds, da, dt, x2, den, t;
    k = it.rate_k; kh = it.half_k; x = it.source_level;
    z = it.aux_level; y = it.target_level;
    rt = 0; ds = 0; da = 0; dt = 0;
    r.hill_error = 1'b0;
    case (op_e'(it.opcode))
      OP_TRANSCRIPTION: begin
        rt = q_mul(k, x); ds = k;
      end
      OP_COACTIVATION, OP_AGGREGATE: begin
        rt = q_mul(q_mul(k, x), z); ds = q_mul(k, z); da = q_mul(k, x);
        if (op_e'(it.opcode) == OP_AGGREGATE && !it.self_is_target) begin
          rt = q_neg(rt); ds = q_neg(ds); da = q_neg(da);
        end
      end
      OP_DEGRADATION, OP_SEQUESTRATION: begin
        rt = q_neg(q_mul(q_mul(k, y), x)); ds = q_neg(q_mul(k, y));
        dt = q_neg(q_mul(k, x));
      end
      OP_HILL: begin
        if (kh <= 0) begin
          r.hill_error = 1'b1;
        end else begin
          x2 = q_mul(x, x);
          den = q_add(kh, x2);
          rt = q_mul(k, q_div(x2, den));
          t = q_mul(q_mul(k, q_div(kh, den)), q_div(x, den));
          ds = q_add(t, t);
        end
      end
      OP_DISAGGREGATE: begin
        rt = q_mul(k, x); ds = k;
        if (it.self_is_source) begin
          rt = q_neg(rt); ds = q_neg(ds);
        end
      end
      default: begin
        rt = q_neg(q_mul(q_mul(q_mul(k, x), z), y));
        ds = q_neg(q_mul(q_mul(k, y), z));
        da = q_neg(q_mul(q_mul(k, y), x));
        dt = q_neg(q_mul(q_mul(k, x), z));
      end
    endcase
    r.rate = rt[31:0]; r.d_source = ds[31:0]; r.d_aux = da[31:0]; r.d_target = dt[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (item_valid && !item_stall)
        expected_q.insert(expected_q.size(), edge_result(item));
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== result) fail_count <= fail_count + 1;
          if (e.rate !== result.rate)
            $error("rate: expected %h, got %h", e.rate, result.rate);
          if (e.d_source !== result.d_source)
            $error("d_source: expected %h, got %h", e.d_source, result.d_source);
          if (e.d_aux !== result.d_aux)
            $error("d_aux: expected %h, got %h", e.d_aux, result.d_aux);
          if (e.d_target !== result.d_target)
            $error("d_target: expected %h, got %h", e.d_target, result.d_target);
          if (e.hill_error !== result.hill_error)
            $error("hill_error: expected %b, got %b", e.hill_error, result.hill_error);
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

[bench/tb_reaction_rate_and_jacobian.sv]
// Testbench top for the edge evaluator: drives edge beats, stalls results, gives the verdict.
module tb_reaction_rate_and_jacobian;
  import rrj_pkg::*;

  localparam int N_RANDOM = 1200;
  localparam int CYCLE_LIMIT = 200000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  int      fail_count, pending;
  int      cycle_count = 0;
  item_t   directed_q[$];

  always #2 clk = ~clk;

  reaction_rate_and_jacobian u_dut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result
  );

  rrj_checker u_chk (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .fail_count, .pending
  );

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 8)) - 4) << 16;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic item_t random_edge();
    item_t it;
    it.opcode = 3'($urandom_range(0, 7));
    it.rate_k = pick_level();
    it.half_k = ($urandom_range(0, 9) == 0) ? pick_level() : 32'($urandom_range(1, 32'h0010_0000));
    it.source_level = pick_level();
    it.aux_level = pick_level();
    it.target_level = pick_level();
    it.self_is_target = 1'($urandom);
    it.self_is_source = 1'($urandom);
    return it;
  endfunction

  task automatic send_edge(input item_t it);
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Receiver: random stalls, quiet stretches, and one long hold-off to fill the block.
  initial begin
    int phase;
    phase = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (40) @(negedge clk);
    result_stall <= 1'b1;
    repeat (300) @(negedge clk);
    forever begin
      phase++;
      if ((phase / 200) % 3 == 0) result_stall <= 1'b0;
      else result_stall <= ($urandom_range(0, 99) < 30);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    item_t it;
    int gap;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed part: every kind at extremes, Hill with bad and good half constants.
    for (int op = 0; op < 8; op++) begin
      it = '{opcode: 3'(op), rate_k: 32'h7fffffff, half_k: 32'h00010000,
             source_level: 32'h80000000, aux_level: 32'h7fffffff,
             target_level: 32'h80000000, self_is_target: 1'b0, self_is_source: 1'b1};
      directed_q.insert(directed_q.size(), it);
      it = '{opcode: 3'(op), rate_k: 32'h00020000, half_k: 32'h00010000,
             source_level: 32'h00018000, aux_level: 32'hffff0000,
             target_level: 32'h00030000, self_is_target: 1'b1, self_is_source: 1'b0};
      directed_q.insert(directed_q.size(), it);
    end
    it = directed_q[0];
    it.opcode = OP_HILL; it.half_k = 32'h0;
    directed_q.insert(directed_q.size(), it);
    it.half_k = 32'h80000000;
    directed_q.insert(directed_q.size(), it);
    it.half_k = 32'h7fffffff; it.source_level = 32'h0;
    directed_q.insert(directed_q.size(), it);
    it.half_k = 32'h00000001; it.source_level = 32'h7fffffff; it.rate_k = 32'h80000000;
    directed_q.insert(directed_q.size(), it);
    foreach (directed_q[i]) send_edge(directed_q[i]);
    // Random part in bursts with gaps.
    for (int n = 0; n < N_RANDOM; ) begin
      for (int b = $urandom_range(1, 30); b > 0 && n < N_RANDOM; b--, n++)
        send_edge(random_edge());
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[sim.f]
src/rrj_pkg.sv
src/rrj_front.sv
src/rrj_fifo.sv
src/rrj_back.sv
src/reaction_rate_and_jacobian.sv
bench/rrj_checker.sv
bench/tb_reaction_rate_and_jacobian.sv
